/* hdl/swm_pkg.sv */
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int WS_BITS         = 7;
    localparam logic [WS_BITS-1:0] WS_RESET = 7'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POPF,
        S_CMP,
        S_PUSH,
        S_FRD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic chk_front;
        logic rd_back;
        logic drop_back;
        logic push;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic seen_full;
        logic back_less;
        logic out_free;
    } t_status;

endpackage

/* hdl/swm_in_if.sv */
interface swm_in_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hdl/swm_out_if.sv */
interface swm_out_if #(
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

/* hdl/swm_ram.sv */
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/swm_ctrl.sv */
module swm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  swm_pkg::t_status i_status,
    output swm_pkg::t_cmd    o_cmd
);
    import swm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_POPF;
                end
            end
            S_POPF: n_state = S_CMP;
            S_CMP: begin
                if (!i_status.back_less) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: n_state = S_FRD;
            S_FRD:  n_state = i_status.seen_full ? S_OUT : S_IDLE;
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            S_POPF: begin
                o_cmd.chk_front = 1'b1;
                o_cmd.rd_back   = 1'b1;
            end
            S_CMP: begin
                o_cmd.rd_back   = 1'b1;
                o_cmd.drop_back = i_status.back_less;
            end
            S_PUSH: o_cmd.push = 1'b1;
            S_FRD:  o_cmd = '0;
            S_OUT:  o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

    a_accept_to_popf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> r_state == S_POPF)
        else $error("accepted request did not start front check");

    a_pop_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drop_back |=> r_state == S_CMP)
        else $error("back pop did not continue comparing");
endmodule

/* hdl/swm_dp.sv */
module swm_dp #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swm_pkg::WS_BITS-1:0]   i_cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  swm_pkg::t_cmd                 i_cmd,
    output swm_pkg::t_status              o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_window_max
);
    import swm_pkg::*;

    localparam int AW = $clog2(MAX_WINDOW);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int WW = (CW > WS_BITS) ? CW : WS_BITS;
    localparam logic [CW:0]   MAXV  = (CW + 1)'(MAX_WINDOW);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_WINDOW);
    localparam logic [WW-1:0] MAXWW = WW'(MAX_WINDOW);

    function automatic logic [AW-1:0] wrap(input logic [CW:0] x);
        wrap = (x >= MAXV) ? AW'(x - MAXV) : AW'(x);
    endfunction

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] x);
        inc = wrap((CW + 1)'(x) + (CW + 1)'(1));
    endfunction

    logic [WS_BITS-1:0]          r_window;
    logic [AW-1:0]               r_front, n_front;
    logic [CW-1:0]               r_fill, n_fill;
    logic [AW-1:0]               r_wp, n_wp;
    logic [CW-1:0]               r_seen, n_seen;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic [WW-1:0]          ws_ext;
    logic [CW-1:0]          eff_w;
    logic                   seen_full;
    logic [AW-1:0]          old_idx;
    logic [SAMPLE_BITS-1:0] hist_rdata;
    logic [SAMPLE_BITS-1:0] deq_rdata;
    logic [AW-1:0]          deq_raddr;
    logic [AW-1:0]          deq_waddr;
    logic                   front_hit;
    logic                   back_less;
    logic                   out_free;
    logic [AW-1:0]          front_g;
    logic [CW-1:0]          fill_g;

    assign ws_ext = WW'(r_window);

    always_comb begin
        if (r_window == '0) begin
            eff_w = CW'(1);
        end else if (ws_ext > MAXWW) begin
            eff_w = MAXC;
        end else begin
            eff_w = CW'(ws_ext);
        end
    end

    assign seen_full = r_seen >= eff_w;
    assign old_idx   = wrap((CW + 1)'(r_wp) + MAXV - (CW + 1)'(eff_w));
    assign front_hit = seen_full && (r_fill != '0) && (deq_rdata == hist_rdata);
    assign back_less = (r_fill != '0) && ($signed(deq_rdata) < r_sample);
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_fill >= MAXC) begin
            front_g = inc(r_front);
            fill_g  = r_fill - CW'(1);
        end else begin
            front_g = r_front;
            fill_g  = r_fill;
        end
    end

    assign deq_waddr = wrap((CW + 1)'(front_g) + (CW + 1)'(fill_g));

    always_comb begin
        n_front = r_front;
        n_fill  = r_fill;
        n_wp    = r_wp;
        n_seen  = r_seen;
        if (i_cfg_we) begin
            n_front = '0;
            n_fill  = '0;
            n_wp    = '0;
            n_seen  = '0;
        end else if (i_cmd.chk_front) begin
            if (front_hit) begin
                n_front = inc(r_front);
                n_fill  = r_fill - CW'(1);
            end
            n_wp = inc(r_wp);
        end else if (i_cmd.drop_back) begin
            n_fill = r_fill - CW'(1);
        end else if (i_cmd.push) begin
            n_front = front_g;
            n_fill  = fill_g + CW'(1);
            if (r_seen < eff_w) begin
                n_seen = r_seen + CW'(1);
            end
        end
    end

    // back of the deque after this cycle's update while rd_back, else the front
    always_comb begin
        if (i_cmd.rd_back && n_fill != '0) begin
            deq_raddr = wrap((CW + 1)'(n_front) + (CW + 1)'(n_fill) - (CW + 1)'(1));
        end else begin
            deq_raddr = r_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WS_RESET;
            r_front     <= '0;
            r_fill      <= '0;
            r_wp        <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            r_front <= n_front;
            r_fill  <= n_fill;
            r_wp    <= n_wp;
            r_seen  <= n_seen;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.out_load) begin
            r_out_data <= $signed(deq_rdata);
        end
    end

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_cmd.chk_front),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_raddr (old_idx),
        .o_rdata (hist_rdata)
    );

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_deq (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (deq_waddr),
        .i_wdata (r_sample),
        .i_raddr (deq_raddr),
        .o_rdata (deq_rdata)
    );

    assign o_status.seen_full = seen_full;
    assign o_status.back_less = back_less;
    assign o_status.out_free  = out_free;
    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MAXC)
        else $error("deque fill exceeds window storage");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.push) |-> r_seen <= eff_w)
        else $error("sample count passed the window");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");
endmodule

/* hdl/sliding_window_max.sv */
// Sliding window maximum over a stream of signed samples.
// Input channel i_in carries one sample per request (valid/ready); output
// channel o_out carries window_max, the largest of the last window_size
// samples including the newest one. No result comes until window_size
// samples have arrived since reset or the last configuration write; after
// that every sample gives exactly one result.
// i_cfg_we/i_cfg_wdata write window_size (0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW); every write empties the window.
// A sample passes from acceptance through the states POPF, CMP, PUSH, FRD
// and OUT to the result register, CMP dropping the smaller values from the
// back of the deque; the next sample is accepted only when the last one is
// done, and each sample is dropped at most once. The pace is set by the
// single read port of the deque memory, which walks the back one entry per
// cycle. Samples that do not yet complete a window skip the OUT state.
// Reset (synchronous, active low) sets window_size to 3 and empties the
// window; there is no memory clearing pass. A stalled receiver keeps the
// result in the output register; the next sample is accepted meanwhile but
// its result waits until the register is free.
module sliding_window_max #(
    parameter int MAX_WINDOW  = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swm_pkg::WS_BITS-1:0] i_cfg_wdata,
    swm_in_if.sink                      i_in,
    swm_out_if.source                   o_out
);
    import swm_pkg::*;

    t_cmd    cmd;
    t_status status;

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swm_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample     (i_in.sample),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_window_max (o_out.window_max)
    );
endmodule

/* bench/sliding_window_max_checker.sv */
`timescale 1ns / 100ps

module sliding_window_max_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [swm_pkg::WS_BITS-1:0] i_cfg_wdata,
    swm_in_if                           i_sample_ch,
    swm_out_if                          i_max_ch,
    output int                          o_mismatches,
    output int                          o_outstanding,
    output int                          o_compared
);
    import swm_pkg::*;

    localparam int DEPTH = MAX_WINDOW_DEF;

    typedef logic signed [SAMPLE_BITS_DEF-1:0] t_sample;

    logic [WS_BITS-1:0] win_reg;
    t_sample            mono_vals [DEPTH];
    t_sample            past_vals [DEPTH];
    int                 mono_head;
    int                 mono_len;
    int                 past_wr;
    int                 filled;
    t_sample            expected_max [$];
    int                 mismatches = 0;
    int                 compared   = 0;

    function automatic int span();
        if (win_reg == '0) begin
            return 1;
        end
        if (int'(win_reg) > DEPTH) begin
            return DEPTH;
        end
        return int'(win_reg);
    endfunction

    task automatic clear_window();
        mono_head = 0;
        mono_len  = 0;
        past_wr   = 0;
        filled    = 0;
    endtask

    task automatic predict_window_max(input t_sample s);
        int w;
        int oldest;
        w = span();
        // drop the front if it is the sample leaving the window
        if (filled >= w) begin
            oldest = (past_wr + DEPTH - w) % DEPTH;
            if (mono_len > 0 && mono_vals[mono_head] == past_vals[oldest]) begin
                mono_head = (mono_head + 1) % DEPTH;
                mono_len--;
            end
        end
        past_vals[past_wr] = s;
        past_wr = (past_wr + 1) % DEPTH;
        // strictly smaller values leave the back, ties stay
        while (mono_len > 0 && mono_vals[(mono_head + mono_len - 1) % DEPTH] < s) begin
            mono_len--;
        end
        if (mono_len >= DEPTH) begin
            mono_head = (mono_head + 1) % DEPTH;
            mono_len--;
        end
        mono_vals[(mono_head + mono_len) % DEPTH] = s;
        mono_len++;
        if (filled < w) begin
            filled++;
        end
        if (filled >= w) begin
            expected_max = {expected_max, mono_vals[mono_head]};
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_sample want;
        if (!i_rst_n) begin
            win_reg = WS_RESET;
            clear_window();
            expected_max.delete();
        end else begin
            if (i_cfg_we) begin
                win_reg = i_cfg_wdata;
                clear_window();
            end
            if (i_max_ch.valid && i_max_ch.ready) begin
                if (expected_max.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: window_max %0d with no request pending",
                                 $realtime, i_max_ch.window_max);
                    end
                end else begin
                    want = expected_max[0];
                    expected_max.delete(0);
                    compared++;
                    if (i_max_ch.window_max !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: window_max expected %0d got %0d",
                                     $realtime, want, i_max_ch.window_max);
                        end
                    end
                end
            end
            if (i_sample_ch.valid && i_sample_ch.ready) begin
                predict_window_max(i_sample_ch.sample);
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_max.size();
        o_compared    <= compared;
    end

endmodule

/* bench/sliding_window_max_tb.sv */
`timescale 1ns / 100ps

module sliding_window_max_tb;
    import swm_pkg::*;

    typedef logic signed [SAMPLE_BITS_DEF-1:0] t_sample;

    localparam t_sample S_MAX     = 32'sh7FFF_FFFF;
    localparam t_sample S_MIN     = 32'sh8000_0000;
    localparam int      DRAIN     = 100;
    localparam int      HOLD_AT   = 200;
    localparam int      LONG_HOLD = 300;
    localparam int      WD_LIMIT  = 3000;
    localparam int      PHASES    = 10;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [WS_BITS-1:0] cfg_wdata;

    int      mismatches;
    int      outstanding;
    int      compared;
    int      sent_count    = 0;
    int      setting_count = 0;
    logic    calm          = 1'b0;
    int      trend         = 0;
    t_sample last_sample   = '0;

    t_sample opening_run [13] = '{S_MAX, S_MIN, S_MIN, -1, 0, 0, 0, 5, 4, 3, 9, S_MIN, 1};
    t_sample narrow_run  [3]  = '{S_MAX, S_MIN, -1};
    int      phase_win   [PHASES] = '{1, 127, 2, 64, 7, 0, 0, 3, 33, 5};
    int      phase_len   [PHASES] = '{40, 110, 50, 100, 60, 30, 60, 50, 80, 40};

    swm_in_if  sample_ch ();
    swm_out_if max_ch ();

    sliding_window_max dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (sample_ch),
        .o_out       (max_ch)
    );

    sliding_window_max_checker checker_u (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_sample_ch   (sample_ch),
        .i_max_ch      (max_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_sample next_sample();
        t_sample v;
        int      r;
        case (trend)
            2: v = last_sample - t_sample'($urandom_range(0, 3));
            3: v = last_sample + t_sample'($urandom_range(0, 3));
            default: begin
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    v = t_sample'($urandom_range(0, 15)) - 8;
                end else if (r < 7) begin
                    v = t_sample'($urandom);
                end else if (r < 8) begin
                    case ($urandom_range(0, 3))
                        0:       v = S_MAX;
                        1:       v = S_MIN;
                        2:       v = 0;
                        default: v = -1;
                    endcase
                end else begin
                    v = last_sample;
                end
            end
        endcase
        last_sample = v;
        return v;
    endfunction

    task automatic send_sample(input t_sample s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge clk); while (!sample_ch.ready);
        sent_count++;
    endtask

    // only while idle: all results in, then a further DRAIN wait
    task automatic set_window(input logic [WS_BITS-1:0] w);
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // output side: random stalls, one long hold-off to back the block up
    initial begin
        int  run_len;
        int  stall;
        bit  held;
        held = 1'b0;
        max_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                max_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = pick_gap();
            if (stall > 0) begin
                max_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            max_ch.ready <= 1'b1;
            run_len = $urandom_range(1, 6);
            repeat (run_len) @(posedge clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WD_LIMIT) begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (max_ch.valid && max_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: %0d cycles without a request or result", WD_LIMIT);
        $display("sliding_window_max_tb NOT OK");
        $finish;
    end

    initial begin
        int p;
        int i;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset window of three: extremes, ties, falling run, full back pop
        foreach (opening_run[k]) begin
            send_sample(opening_run[k]);
        end
        // zero acts as a one-sample window
        set_window('0);
        foreach (narrow_run[k]) begin
            send_sample(narrow_run[k]);
        end

        phase_win[6] = $urandom_range(1, 64);
        for (p = 0; p < PHASES; p++) begin
            set_window(WS_BITS'(phase_win[p]));
            for (i = 0; i < phase_len[p]; i++) begin
                if (i % 16 == 0) begin
                    trend = $urandom_range(0, 3);
                    calm  = ($urandom_range(0, 4) == 0);
                end
                send_sample(next_sample());
            end
        end
        calm = 1'b0;

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d samples over %0d window sizes (0, 1, 64, 127 among them), %0d maxima",
                 sent_count, setting_count + 1, compared);
        $display("checked, with ties, rising and falling runs and a long output hold-off");
        if (mismatches == 0) begin
            $display("sliding_window_max_tb OK");
        end else begin
            $display("sliding_window_max_tb NOT OK");
        end
        $finish;
    end

endmodule
